/* design/box_filter_line_top_defines.svh */
// Assertion macros for the box filter line block.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef BOX_FILTER_LINE_TOP_DEFINES_SVH
`define BOX_FILTER_LINE_TOP_DEFINES_SVH
`ifndef SYNTH
`define BFL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define BFL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define BFL_ASSERT(lbl, prop, msg)
`define BFL_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

/* design/bfl_pkg.sv */
`timescale 1ns / 1ps
package bfl_pkg;

  localparam int PIX_W          = 8;
  localparam int PIX_MAX        = 255;
  localparam int RADIUS_W       = 4;
  localparam int RADIUS_LIMIT   = 15;
  localparam int MAX_RADIUS_DEF = 15;
  localparam int SUM_W_DEF      = 13;

  localparam logic [RADIUS_W-1:0] RADIUS_RST = RADIUS_W'(1);

  typedef struct packed {
    logic [PIX_W-1:0] pixel_in;
    logic             line_end_in;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             line_end_out;
  } out_t;

endpackage

/* design/box_filter_line_top.sv */
`timescale 1ns / 1ps
// Streaming 1-D box filter over one image line, border pixels replicated.
// Each output word is the truncated mean of the 2r+1 pixels centred on it;
// outputs lag the input by r pixels and the word flagged last-of-line
// flushes the rest of the line, the final one carrying line_end_out.
// Pixels sit in a chain of cells that advances once per accepted word. One
// item is worked on at a time: a word yielding no result is only stored,
// and each result passes through window mask, partial sums, total, two
// divider stages and output load, where the output side can stall it. A
// line end yields up to r+1 results, each taking those steps. The radius
// register takes a write every cycle and must only be written while no
// item is in progress; values above the supported radius saturate. No
// clearing pass follows reset.
module box_filter_line_top #(
  parameter int MAX_RADIUS = bfl_pkg::MAX_RADIUS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  bfl_pkg::in_t                 in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output bfl_pkg::out_t                out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bfl_pkg::RADIUS_W-1:0] cfg_data_i
);

`include "box_filter_line_top_defines.svh"

  localparam int PIX_W  = bfl_pkg::PIX_W;
  localparam int RAD_W  = bfl_pkg::RADIUS_W;
  localparam int DEPTH  = 2 * MAX_RADIUS + 1;
  localparam int SEEN_W = $clog2(DEPTH + 1);
  // the radius register is 4 bits, so no window ever spans more cells
  localparam int RMAX   = (MAX_RADIUS < bfl_pkg::RADIUS_LIMIT) ? MAX_RADIUS
                                                               : bfl_pkg::RADIUS_LIMIT;
  localparam int NCELL  = 2 * RMAX + 1;
  localparam int CIDX_W = $clog2(NCELL);
  localparam int HI_W   = RAD_W + 1;
  localparam int CMP_W  = (SEEN_W > HI_W) ? SEEN_W : HI_W;
  localparam int SUM_W  = $clog2(NCELL * bfl_pkg::PIX_MAX + 1);
  localparam int PART_W = PIX_W + 2;
  localparam int NGRP   = (NCELL + 3) / 4;
  localparam logic [SEEN_W-1:0] SEEN_SAT = SEEN_W'(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MASK,
    S_PART,
    S_SUM,
    S_DIVA,
    S_DIVB,
    S_EMIT
  } state_e;

  state_e              state_q, state_d;
  logic [SEEN_W-1:0]   seen_q, seen_d;
  logic [RAD_W-1:0]    back_q, back_d;
  logic                last_q, last_d;
  logic [RAD_W-1:0]    radius_q, radius_d;
  logic                out_valid_q, out_valid_d;
  bfl_pkg::out_t       out_q, out_d;

  logic [RAD_W-1:0]    r_eff;
  logic                in_acc;
  logic [SEEN_W-1:0]   seen_inc;
  logic                has_main;
  logic [HI_W-1:0]     hi_sum;
  logic [SEEN_W-1:0]   lim;
  logic                over;
  logic [CIDX_W-1:0]   hi_c;
  logic [HI_W-1:0]     above;
  logic [RAD_W-1:0]    below;
  logic                emit_go;
  logic                more;

  logic [PIX_W-1:0]    pix    [NCELL];
  logic [PIX_W-1:0]    masked [NGRP*4];
  logic [SUM_W-1:0]    edge_d, edge_q;
  logic [PART_W-1:0]   part_d [NGRP];
  logic [PART_W-1:0]   part_q [NGRP];
  logic [SUM_W-1:0]    sum_d, sum_q;
  logic [PIX_W-1:0]    quo;

  // ---------------------------------------------------------------------
  // Window geometry for the output centred back_q pixels behind the newest.
  // The left edge always reaches or passes the newest pixel, so the window
  // starts at cell 0 and r - back positions replicate the newest pixel.
  // The right edge clamps to the oldest pixel held for this line.
  // ---------------------------------------------------------------------
  assign r_eff    = (radius_q > RAD_W'(RMAX)) ? RAD_W'(RMAX) : radius_q;
  assign in_acc   = in_valid_i && (state_q == S_IDLE);
  assign seen_inc = (seen_q == SEEN_SAT) ? seen_q : seen_q + 1'b1;
  assign has_main = CMP_W'(seen_inc) > CMP_W'(r_eff);
  assign hi_sum   = HI_W'(back_q) + HI_W'(r_eff);
  assign lim      = seen_q - 1'b1;
  assign over     = CMP_W'(hi_sum) > CMP_W'(lim);
  assign hi_c     = over ? CIDX_W'(lim) : CIDX_W'(hi_sum);
  assign above    = over ? HI_W'(CMP_W'(hi_sum) - CMP_W'(lim)) : '0;
  assign below    = r_eff - back_q;
  assign emit_go  = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);
  assign more     = last_q && (back_q != '0);

  // ---------------------------------------------------------------------
  // Pixel chain: cell 0 holds the newest pixel of the line.
  // ---------------------------------------------------------------------
  for (genvar d = 0; d < NCELL; d++) begin : g_cell
    logic [PIX_W-1:0] feed;
    if (d == 0) begin : g_head
      assign feed = in_data_i.pixel_in;
    end else begin : g_link
      assign feed = pix[d-1];
    end
    bfl_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (in_acc),
      .sel_i   (CIDX_W'(d) <= hi_c),
      .pix_i   (feed),
      .pix_o   (pix[d]),
      .mask_o  (masked[d])
    );
  end

  // pad the last group of four with zeros
  for (genvar d = NCELL; d < NGRP * 4; d++) begin : g_pad
    assign masked[d] = '0;
  end

  // ---------------------------------------------------------------------
  // Sum pipeline: replicated border terms and groups of four cells, then
  // the total. All stages run free; the sequencer samples at fixed points.
  // ---------------------------------------------------------------------
  assign edge_d = SUM_W'(below) * SUM_W'(pix[0]) + SUM_W'(above) * SUM_W'(pix[hi_c]);

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      part_d[g] = PART_W'(masked[4*g]) + PART_W'(masked[4*g+1])
                + PART_W'(masked[4*g+2]) + PART_W'(masked[4*g+3]);
    end
  end

  always_comb begin
    sum_d = edge_q;
    for (int g = 0; g < NGRP; g++) begin
      sum_d = sum_d + SUM_W'(part_q[g]);
    end
  end

  always_ff @(posedge clk_i) begin
    edge_q <= edge_d;
    part_q <= part_d;
    sum_q  <= sum_d;
  end

  bfl_div #(
    .SUM_W (SUM_W)
  ) u_div (
    .clk_i (clk_i),
    .sum_i (sum_q),
    .rad_i (r_eff),
    .quo_o (quo)
  );

  // ---------------------------------------------------------------------
  // Sequencer: accept a word, walk the window mask through the pipeline,
  // load the result into the output register, then either flush the next
  // output of the line or go back to accepting.
  // ---------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    seen_d      = seen_q;
    back_d      = back_q;
    last_d      = last_q;
    radius_d    = radius_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cfg_valid_i) begin
      radius_d = cfg_data_i;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          seen_d = seen_inc;
          last_d = in_data_i.line_end_in;
          // first output is centred r back, or on the oldest pixel of a
          // line still holding no more than r pixels
          back_d = has_main ? r_eff : RAD_W'(seen_inc - 1'b1);
          if (has_main || in_data_i.line_end_in) begin
            state_d = S_MASK;
          end
        end
      end
      S_MASK: state_d = S_PART;
      S_PART: state_d = S_SUM;
      S_SUM:  state_d = S_DIVA;
      S_DIVA: state_d = S_DIVB;
      S_DIVB: state_d = S_EMIT;
      S_EMIT: begin
        if (emit_go) begin
          out_valid_d        = 1'b1;
          out_d.pixel_out    = quo;
          out_d.line_end_out = last_q && (back_q == '0);
          if (more) begin
            back_d  = back_q - 1'b1;
            state_d = S_MASK;
          end else begin
            if (last_q) begin
              seen_d = '0;
            end
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      seen_q      <= '0;
      back_q      <= '0;
      last_q      <= 1'b0;
      radius_q    <= bfl_pkg::RADIUS_RST;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      seen_q      <= seen_d;
      back_q      <= back_d;
      last_q      <= last_d;
      radius_q    <= radius_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  `BFL_ASSERT(a_word_from_emit, $rose(out_valid_q) |-> $past(state_q == S_EMIT), "output word loaded outside emit")
  `BFL_ASSERT_IMP(a_busy_has_pixels, state_q != S_IDLE, seen_q != '0, "busy with no pixel held")
  `BFL_ASSERT(a_line_end_restarts, (emit_go && last_q && back_q == '0) |=> (seen_q == '0 && state_q == S_IDLE), "line end did not restart the line")

endmodule

/* design/bfl_cell.sv */
`timescale 1ns / 1ps
// One tap of the pixel chain: hold a pixel, pass it on when the chain
// advances, and present it masked by the window select.
module bfl_cell (
  input  logic                       clk_i,
  input  logic                       shift_i,
  input  logic                       sel_i,
  input  logic [bfl_pkg::PIX_W-1:0]  pix_i,
  output logic [bfl_pkg::PIX_W-1:0]  pix_o,
  output logic [bfl_pkg::PIX_W-1:0]  mask_o
);

  logic [bfl_pkg::PIX_W-1:0] pix_q;
  logic [bfl_pkg::PIX_W-1:0] mask_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      pix_q <= pix_i;
    end
    mask_q <= sel_i ? pix_q : '0;
  end

  assign pix_o  = pix_q;
  assign mask_o = mask_q;

endmodule

/* design/bfl_div.sv */
`timescale 1ns / 1ps
// Divide the window sum by 2r+1: reciprocal multiply, then one correction.
module bfl_div #(
  parameter int SUM_W = bfl_pkg::SUM_W_DEF
) (
  input  logic                         clk_i,
  input  logic [SUM_W-1:0]             sum_i,
  input  logic [bfl_pkg::RADIUS_W-1:0] rad_i,
  output logic [bfl_pkg::PIX_W-1:0]    quo_o
);

  localparam int RCP_W  = SUM_W + 1;
  localparam int DIV_W  = bfl_pkg::RADIUS_W + 1;
  localparam int PROD_W = SUM_W + RCP_W;
  localparam int NRAD   = 1 << bfl_pkg::RADIUS_W;

  logic [RCP_W-1:0]          rcp_tab [NRAD];
  logic [PROD_W-1:0]         prod;
  logic [SUM_W-1:0]          qd;
  logic [SUM_W-1:0]          rem;
  logic [bfl_pkg::PIX_W-1:0] q0_q;
  logic [SUM_W-1:0]          s_q;
  logic [DIV_W-1:0]          d_q;
  logic [bfl_pkg::PIX_W-1:0] quo_q;

  // floor(2^SUM_W / (2g+1)); the estimate is at most one below the quotient
  for (genvar g = 0; g < NRAD; g++) begin : g_rcp
    localparam int RV = (1 << SUM_W) / (2 * g + 1);
    assign rcp_tab[g] = RCP_W'(RV);
  end

  assign prod = PROD_W'(sum_i) * PROD_W'(rcp_tab[rad_i]);
  assign qd   = SUM_W'(q0_q) * SUM_W'(d_q);
  assign rem  = s_q - qd;

  always_ff @(posedge clk_i) begin
    q0_q  <= bfl_pkg::PIX_W'(prod >> SUM_W);
    s_q   <= sum_i;
    d_q   <= {rad_i, 1'b1};
    quo_q <= (rem >= SUM_W'(d_q)) ? q0_q + 1'b1 : q0_q;
  end

  assign quo_o = quo_q;

endmodule
